[sv/vrt_pkg.sv]
// Shared types and constants for the voxel ray traversal unit.
package vrt_pkg;

  localparam int CELL_BITS  = 24;
  localparam int FRAC_BITS  = 8;
  localparam int Y_BITS     = 8;
  localparam int LEN_BITS   = 24;
  localparam int STEP_BITS  = 16;
  localparam int REACH_BITS = 13;
  localparam int POS_BITS   = 32;
  localparam int YPOS_BITS  = 16;
  localparam int ADDR_BITS  = 3;
  localparam int REG_LSB    = 2;

  localparam logic [REACH_BITS-1:0] REACH_RESET = 13'd1280;
  localparam logic [STEP_BITS-1:0]  STEP_INF    = {STEP_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX     = {LEN_BITS{1'b1}};
  localparam logic [LEN_BITS:0]     KEY_INF     = {1'b1, {LEN_BITS{1'b0}}};
  localparam logic [Y_BITS-1:0]     Y_TOP       = {Y_BITS{1'b1}};
  localparam logic [FRAC_BITS:0]    ONE_FIX     = {1'b1, {FRAC_BITS{1'b0}}};

  // Register indexes (byte address bits above REG_LSB).
  localparam logic [ADDR_BITS-REG_LSB-1:0] REG_REACH = 1'b0;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ANSWER = 1'b1
  } vrt_op_t;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2,
    KIND_IDLE  = 2'd3
  } vrt_kind_t;

  typedef struct packed {
    vrt_op_t                      opcode;
    logic                         action;
    logic signed [POS_BITS-1:0]   start_x;
    logic [YPOS_BITS-1:0]         start_y;
    logic signed [POS_BITS-1:0]   start_z;
    logic                         heads_neg_x;
    logic                         heads_neg_y;
    logic                         heads_neg_z;
    logic [STEP_BITS-1:0]         inv_dir_x;
    logic [STEP_BITS-1:0]         inv_dir_y;
    logic [STEP_BITS-1:0]         inv_dir_z;
    logic                         occupied;
  } vrt_in_t;

  typedef struct packed {
    vrt_kind_t                    kind;
    logic signed [CELL_BITS-1:0]  cell_x;
    logic [Y_BITS-1:0]            cell_y;
    logic signed [CELL_BITS-1:0]  cell_z;
  } vrt_out_t;

endpackage

[sv/voxel_ray_traversal_unit.sv]
// Voxel ray traversal unit: fixed-point 3D grid walk driven by probe/answer transactions.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-----------------------------
//  item      | in  | item_valid / item_ready       | vrt_in_t (start or answer)
//  result    | out | result_valid / result_ready   | vrt_out_t (probe/hit/miss)
//  config    | in  | psel / penable / pwrite       | reach at byte address 0
//
//  Throughput is one transaction per cycle unless results stall; each item crosses both stages.
//  The first stage computes the initial axis lengths (one 9x16 multiply per axis) into
//  the input register; the second stage runs one ray step (axis pick, add, saturate,
//  tie and reach check) against the walk state and loads the result register.
//  The walk-state feedback in the second stage sets the one-cycle rate.
//  rst is synchronous: it empties both stages, stops any walk and restores reach to 1280.
//  A stalled result holds in its register; the input stage keeps accepting while the
//  result register is free or being taken.
module voxel_ray_traversal_unit import vrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  vrt_in_t              item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output vrt_out_t             result
);

  // Ray length to the first boundary: (f or ONE - f) * inv >> FRAC_BITS.
  function automatic logic [STEP_BITS-1:0] first_len(input logic [FRAC_BITS-1:0] frac,
                                                     input logic neg,
                                                     input logic [STEP_BITS-1:0] inv);
    logic [FRAC_BITS:0]           d;
    logic [FRAC_BITS+STEP_BITS:0] p;
    d = neg ? {1'b0, frac} : ONE_FIX - {1'b0, frac};
    p = (FRAC_BITS+STEP_BITS+1)'(d) * (FRAC_BITS+STEP_BITS+1)'(inv);
    return p[FRAC_BITS+STEP_BITS-1:FRAC_BITS];
  endfunction

  // An infinite step turns the axis into a key above every finite length.
  function automatic logic [LEN_BITS:0] key_of(input logic [STEP_BITS-1:0] step,
                                               input logic [LEN_BITS-1:0] len);
    return (step == STEP_INF) ? KEY_INF : {1'b0, len};
  endfunction

  // Walk continues only below reach, with at least one finite axis and without a tie between finite axes.
  function automatic logic may_go(input logic [LEN_BITS:0] kx,
                                  input logic [LEN_BITS:0] ky,
                                  input logic [LEN_BITS:0] kz,
                                  input logic [LEN_BITS-1:0] trav,
                                  input logic [REACH_BITS-1:0] lim);
    logic ok;
    logic fx;
    logic fy;
    logic fz;
    fx = (kx != KEY_INF);
    fy = (ky != KEY_INF);
    fz = (kz != KEY_INF);
    ok = (trav < LEN_BITS'(lim));
    if (!fx && !fy && !fz) ok = 1'b0;
    if (fx && (kx == ky)) ok = 1'b0;
    if (fx && (kx == kz)) ok = 1'b0;
    if (fy && (ky == kz)) ok = 1'b0;
    return ok;
  endfunction

  // ---------------------------------------------------------------- config
  logic [REACH_BITS-1:0] reach;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_BITS-1:REG_LSB] == REG_REACH);

  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= REACH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      reach <= pwdata[REACH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = 32'(reach);
    end
  end

  // ---------------------------------------------------------------- input stage
  logic                 s1_valid;
  logic                 s1_move;
  vrt_in_t              s1_item;
  logic [STEP_BITS-1:0] s1_len_x;
  logic [STEP_BITS-1:0] s1_len_y;
  logic [STEP_BITS-1:0] s1_len_z;

  // Advance the step stage whenever the result register is free or draining.
  assign s1_move    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  // Precompute the start lengths so the step stage holds no multiplier.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item  <= item;
      s1_len_x <= first_len(item.start_x[FRAC_BITS-1:0], item.heads_neg_x, item.inv_dir_x);
      s1_len_y <= first_len(item.start_y[FRAC_BITS-1:0], item.heads_neg_y, item.inv_dir_y);
      s1_len_z <= first_len(item.start_z[FRAC_BITS-1:0], item.heads_neg_z, item.inv_dir_z);
    end
  end

  // ---------------------------------------------------------------- walk state
  logic                 walking;
  logic                 place_mode;
  logic [CELL_BITS-1:0] cur_x, cur_z, prev_x, prev_z;
  logic [Y_BITS-1:0]    cur_y, prev_y;
  logic [LEN_BITS-1:0]  len_x, len_y, len_z;
  logic [STEP_BITS-1:0] step_x, step_y, step_z;
  logic [2:0]           neg;
  logic [LEN_BITS-1:0]  trav;

  logic                 walking_next;
  logic                 place_mode_next;
  logic [CELL_BITS-1:0] cur_x_next, cur_z_next, prev_x_next, prev_z_next;
  logic [Y_BITS-1:0]    cur_y_next, prev_y_next;
  logic [LEN_BITS-1:0]  len_x_next, len_y_next, len_z_next;
  logic [STEP_BITS-1:0] step_x_next, step_y_next, step_z_next;
  logic [2:0]           neg_next;
  logic [LEN_BITS-1:0]  trav_next;
  vrt_out_t             res_next;

  // Base state: a start item replaces the ray, an answer works on the held one.
  logic                 is_start;
  logic [CELL_BITS-1:0] b_cx, b_cz;
  logic [Y_BITS-1:0]    b_cy;
  logic [LEN_BITS-1:0]  b_lx, b_ly, b_lz, b_trav;
  logic [STEP_BITS-1:0] b_sx, b_sy, b_sz;
  logic [2:0]           b_neg;
  logic [LEN_BITS:0]    kx, ky, kz;
  logic                 go_base;

  // One ray step from the base state.
  logic                 sel_x, sel_y;
  logic [LEN_BITS-1:0]  pick_len;
  logic [STEP_BITS-1:0] pick_step;
  logic [LEN_BITS:0]    sum;
  logic [LEN_BITS-1:0]  sat;
  logic                 adv_ok;
  logic [CELL_BITS-1:0] a_cx, a_cz;
  logic [Y_BITS-1:0]    a_cy;
  logic [LEN_BITS-1:0]  a_lx, a_ly, a_lz;
  logic                 go_adv;
  logic                 place_step;

  always_comb begin
    is_start = (s1_item.opcode == OP_START);
    if (is_start) begin
      b_cx   = s1_item.start_x[FRAC_BITS+CELL_BITS-1:FRAC_BITS];
      b_cy   = s1_item.start_y[FRAC_BITS+Y_BITS-1:FRAC_BITS];
      b_cz   = s1_item.start_z[FRAC_BITS+CELL_BITS-1:FRAC_BITS];
      b_lx   = LEN_BITS'(s1_len_x);
      b_ly   = LEN_BITS'(s1_len_y);
      b_lz   = LEN_BITS'(s1_len_z);
      b_sx   = s1_item.inv_dir_x;
      b_sy   = s1_item.inv_dir_y;
      b_sz   = s1_item.inv_dir_z;
      b_neg  = {s1_item.heads_neg_z, s1_item.heads_neg_y, s1_item.heads_neg_x};
      b_trav = '0;
    end else begin
      b_cx   = cur_x;
      b_cy   = cur_y;
      b_cz   = cur_z;
      b_lx   = len_x;
      b_ly   = len_y;
      b_lz   = len_z;
      b_sx   = step_x;
      b_sy   = step_y;
      b_sz   = step_z;
      b_neg  = neg;
      b_trav = trav;
    end

    kx      = key_of(b_sx, b_lx);
    ky      = key_of(b_sy, b_ly);
    kz      = key_of(b_sz, b_lz);
    go_base = may_go(kx, ky, kz, b_trav, reach);

    // Smallest key wins; ties fall through to the later axis.
    sel_x = (kx < ky) && (kx < kz);
    sel_y = !sel_x && (ky < kz);

    pick_len  = sel_x ? b_lx : (sel_y ? b_ly : b_lz);
    pick_step = sel_x ? b_sx : (sel_y ? b_sy : b_sz);
    sum       = {1'b0, pick_len} + (LEN_BITS+1)'(pick_step);
    sat       = sum[LEN_BITS] ? LEN_MAX : sum[LEN_BITS-1:0];

    // Height stays inside 0..255; x and z wrap.
    adv_ok = !(sel_y && (b_neg[1] ? (b_cy == '0) : (b_cy == Y_TOP)));
    a_cx   = b_cx;
    a_cy   = b_cy;
    a_cz   = b_cz;
    a_lx   = b_lx;
    a_ly   = b_ly;
    a_lz   = b_lz;
    if (sel_x) begin
      a_cx = b_neg[0] ? b_cx - CELL_BITS'(1) : b_cx + CELL_BITS'(1);
      a_lx = sat;
    end else if (sel_y) begin
      a_cy = b_neg[1] ? b_cy - Y_BITS'(1) : b_cy + Y_BITS'(1);
      a_ly = sat;
    end else begin
      a_cz = b_neg[2] ? b_cz - CELL_BITS'(1) : b_cz + CELL_BITS'(1);
      a_lz = sat;
    end
    go_adv = may_go(key_of(b_sx, a_lx), key_of(b_sy, a_ly), key_of(b_sz, a_lz),
                    pick_len, reach);

    // Place mode steps before it probes, on a start and on every empty answer.
    place_step = (is_start && s1_item.action) ||
                 (!is_start && walking && !s1_item.occupied && place_mode);

    // Hold state by default.
    walking_next    = walking;
    place_mode_next = place_mode;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    cur_z_next      = cur_z;
    prev_x_next     = prev_x;
    prev_y_next     = prev_y;
    prev_z_next     = prev_z;
    len_x_next      = len_x;
    len_y_next      = len_y;
    len_z_next      = len_z;
    step_x_next     = step_x;
    step_y_next     = step_y;
    step_z_next     = step_z;
    neg_next        = neg;
    trav_next       = trav;
    res_next        = '{kind: KIND_MISS, cell_x: '0, cell_y: '0, cell_z: '0};

    if (is_start) begin
      walking_next    = 1'b1;
      place_mode_next = s1_item.action;
      cur_x_next      = b_cx;
      cur_y_next      = b_cy;
      cur_z_next      = b_cz;
      len_x_next      = b_lx;
      len_y_next      = b_ly;
      len_z_next      = b_lz;
      step_x_next     = b_sx;
      step_y_next     = b_sy;
      step_z_next     = b_sz;
      neg_next        = b_neg;
      trav_next       = '0;
    end

    if (place_step) begin
      prev_x_next = b_cx;
      prev_y_next = b_cy;
      prev_z_next = b_cz;
      if (go_base && adv_ok) begin
        cur_x_next = a_cx;
        cur_y_next = a_cy;
        cur_z_next = a_cz;
        len_x_next = a_lx;
        len_y_next = a_ly;
        len_z_next = a_lz;
        trav_next  = pick_len;
        res_next   = '{kind: KIND_PROBE, cell_x: a_cx, cell_y: a_cy, cell_z: a_cz};
      end else begin
        walking_next = 1'b0;
      end
    end else if (is_start) begin
      // Break mode probes the start cell first.
      if (go_base) begin
        res_next = '{kind: KIND_PROBE, cell_x: b_cx, cell_y: b_cy, cell_z: b_cz};
      end else begin
        walking_next = 1'b0;
      end
    end else if (!walking) begin
      res_next.kind = KIND_IDLE;
    end else if (s1_item.occupied) begin
      walking_next = 1'b0;
      if (place_mode) begin
        res_next = '{kind: KIND_HIT, cell_x: prev_x, cell_y: prev_y, cell_z: prev_z};
      end else begin
        res_next = '{kind: KIND_HIT, cell_x: cur_x, cell_y: cur_y, cell_z: cur_z};
      end
    end else begin
      // Break mode steps after an empty answer, then checks the new lengths.
      if (adv_ok) begin
        cur_x_next = a_cx;
        cur_y_next = a_cy;
        cur_z_next = a_cz;
        len_x_next = a_lx;
        len_y_next = a_ly;
        len_z_next = a_lz;
        trav_next  = pick_len;
      end
      if (adv_ok && go_adv) begin
        res_next = '{kind: KIND_PROBE, cell_x: a_cx, cell_y: a_cy, cell_z: a_cz};
      end else begin
        walking_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking    <= 1'b0;
      place_mode <= 1'b0;
    end else if (s1_move) begin
      walking    <= walking_next;
      place_mode <= place_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      cur_x  <= cur_x_next;
      cur_y  <= cur_y_next;
      cur_z  <= cur_z_next;
      prev_x <= prev_x_next;
      prev_y <= prev_y_next;
      prev_z <= prev_z_next;
      len_x  <= len_x_next;
      len_y  <= len_y_next;
      len_z  <= len_z_next;
      step_x <= step_x_next;
      step_y <= step_y_next;
      step_z <= step_z_next;
      neg    <= neg_next;
      trav   <= trav_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result <= res_next;
    end
  end

  // ---------------------------------------------------------------- checks
  a_end_stops_walk: assert property (@(posedge clk) disable iff (rst)
    s1_move && ((res_next.kind == KIND_HIT) || (res_next.kind == KIND_MISS)) |=> !walking)
    else $error("walk still active after hit or miss");

  a_probe_keeps_walk: assert property (@(posedge clk) disable iff (rst)
    s1_move && (res_next.kind == KIND_PROBE) |=> walking)
    else $error("probe issued without an active walk");

  a_idle_answer: assert property (@(posedge clk) disable iff (rst)
    s1_move && (s1_item.opcode == OP_ANSWER) && !walking |-> res_next.kind == KIND_IDLE)
    else $error("answer while idle not reported as idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && s1_valid |-> s1_move)
    else $error("input stage overwritten while occupied");

endmodule

[tb/sv/voxel_ray_traversal_unit_tb.sv]
// Self-checking testbench for the voxel ray traversal unit.
module voxel_ray_traversal_unit_tb;
  import vrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 140;
  localparam int PRINT_CAP = 40;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  vrt_in_t              item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  vrt_out_t             result;

  voxel_ray_traversal_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Ray walker state as the testbench sees it; cells are kept at full
  // horizontal width, with the height in the low bits of index 1.
  logic [REACH_BITS-1:0] reach_cfg = REACH_RESET;
  bit                    walk_on;
  bit                    place_on;
  logic [CELL_BITS-1:0]  cell_at [3];
  logic [CELL_BITS-1:0]  prev_at [3];
  logic [LEN_BITS-1:0]   axis_len [3];
  logic [STEP_BITS-1:0]  axis_step [3];
  logic [2:0]            axis_neg;
  logic [LEN_BITS-1:0]   walked_len;

  vrt_out_t ray_results_due [$];
  int       bad_fields = 0;
  int       results_seen = 0;
  int       fed_items = 0;
  int       stall_left = 0;
  bit       calm = 1'b0;
  int unsigned cycle_count = 0;

  typedef struct {
    vrt_in_t  it;
    bit       typed;
    vrt_out_t want;
  } ray_case_t;

  ray_case_t directed_rays [$];

  function automatic logic [CELL_BITS-1:0] floor_cell(logic signed [POS_BITS-1:0] raw);
    logic signed [POS_BITS-1:0] s;
    s = raw >>> FRAC_BITS;
    return s[CELL_BITS-1:0];
  endfunction

  // Distance from the start point to the first boundary on one axis.
  function automatic logic [LEN_BITS-1:0] entry_len(logic [FRAC_BITS-1:0] f, bit n,
                                                    logic [STEP_BITS-1:0] inv);
    logic [FRAC_BITS:0] d;
    logic [31:0]        p;
    d = n ? {1'b0, f} : ONE_FIX - f;
    p = (32'(d) * 32'(inv)) >> FRAC_BITS;
    return (p > LEN_MAX) ? LEN_MAX : p[LEN_BITS-1:0];
  endfunction

  // An infinite axis sorts above every finite length.
  function automatic logic [LEN_BITS:0] axis_key(int a);
    return (axis_step[a] == STEP_INF) ? KEY_INF : {1'b0, axis_len[a]};
  endfunction

  function automatic bit can_step();
    logic [LEN_BITS:0] kx, ky, kz;
    kx = axis_key(0);
    ky = axis_key(1);
    kz = axis_key(2);
    if (walked_len >= reach_cfg) return 1'b0;
    if (kx == KEY_INF && ky == KEY_INF && kz == KEY_INF) return 1'b0;
    if (kx != KEY_INF && kx == ky) return 1'b0;
    if (kx != KEY_INF && kx == kz) return 1'b0;
    if (ky != KEY_INF && ky == kz) return 1'b0;
    return 1'b1;
  endfunction

  // Cross the nearest boundary; refuse when the height would leave range.
  function automatic bit take_step();
    logic [LEN_BITS:0] kx, ky, kz, sum;
    int a;
    kx = axis_key(0);
    ky = axis_key(1);
    kz = axis_key(2);
    if (kx < ky && kx < kz) a = 0;
    else if (ky < kz) a = 1;
    else a = 2;
    if (a == 1) begin
      if (axis_neg[1] && cell_at[1] == 0) return 1'b0;
      if (!axis_neg[1] && cell_at[1] >= CELL_BITS'(Y_TOP)) return 1'b0;
    end
    cell_at[a] = axis_neg[a] ? cell_at[a] - 1'b1 : cell_at[a] + 1'b1;
    walked_len = axis_len[a];
    sum = {1'b0, axis_len[a]} + (LEN_BITS+1)'(axis_step[a]);
    axis_len[a] = (sum > LEN_MAX) ? LEN_MAX : sum[LEN_BITS-1:0];
    return 1'b1;
  endfunction

  function automatic vrt_out_t cell_out(vrt_kind_t k, bit from_prev);
    vrt_out_t r;
    r.kind   = k;
    r.cell_x = from_prev ? prev_at[0] : cell_at[0];
    r.cell_y = from_prev ? prev_at[1][Y_BITS-1:0] : cell_at[1][Y_BITS-1:0];
    r.cell_z = from_prev ? prev_at[2] : cell_at[2];
    return r;
  endfunction

  function automatic vrt_out_t ray_miss();
    vrt_out_t r;
    walk_on = 1'b0;
    r = '0;
    r.kind = KIND_MISS;
    return r;
  endfunction

  function automatic vrt_out_t place_step();
    prev_at = cell_at;
    if (!can_step()) return ray_miss();
    if (!take_step()) return ray_miss();
    return cell_out(KIND_PROBE, 1'b0);
  endfunction

  // Advance the walker by one transaction and return the result it owes.
  function automatic vrt_out_t predict_ray(vrt_in_t it);
    vrt_out_t r;
    r = '0;
    if (it.opcode == OP_START) begin
      axis_step[0] = it.inv_dir_x;
      axis_step[1] = it.inv_dir_y;
      axis_step[2] = it.inv_dir_z;
      axis_neg     = {it.heads_neg_z, it.heads_neg_y, it.heads_neg_x};
      cell_at[0]   = floor_cell(it.start_x);
      cell_at[1]   = CELL_BITS'(it.start_y[YPOS_BITS-1:FRAC_BITS]);
      cell_at[2]   = floor_cell(it.start_z);
      axis_len[0]  = entry_len(it.start_x[FRAC_BITS-1:0], it.heads_neg_x, it.inv_dir_x);
      axis_len[1]  = entry_len(it.start_y[FRAC_BITS-1:0], it.heads_neg_y, it.inv_dir_y);
      axis_len[2]  = entry_len(it.start_z[FRAC_BITS-1:0], it.heads_neg_z, it.inv_dir_z);
      walked_len   = '0;
      walk_on      = 1'b1;
      place_on     = it.action;
      if (place_on) r = place_step();
      else if (!can_step()) r = ray_miss();
      else r = cell_out(KIND_PROBE, 1'b0);
    end else if (!walk_on) begin
      r.kind = KIND_IDLE;
    end else if (it.occupied) begin
      walk_on = 1'b0;
      r = cell_out(KIND_HIT, place_on);
    end else if (place_on) begin
      r = place_step();
    end else if (!take_step()) begin
      r = ray_miss();
    end else if (!can_step()) begin
      r = ray_miss();
    end else begin
      r = cell_out(KIND_PROBE, 1'b0);
    end
    return r;
  endfunction

  function automatic vrt_in_t mk_start(bit act, logic [31:0] sx, logic [15:0] sy,
                                       logic [31:0] sz, logic [2:0] neg,
                                       logic [15:0] ix, logic [15:0] iy, logic [15:0] iz);
    vrt_in_t it;
    it = '0;
    it.opcode      = OP_START;
    it.action      = act;
    it.start_x     = sx;
    it.start_y     = sy;
    it.start_z     = sz;
    it.heads_neg_x = neg[0];
    it.heads_neg_y = neg[1];
    it.heads_neg_z = neg[2];
    it.inv_dir_x   = ix;
    it.inv_dir_y   = iy;
    it.inv_dir_z   = iz;
    return it;
  endfunction

  function automatic vrt_in_t mk_answer(bit occ);
    vrt_in_t it;
    it = '0;
    it.opcode   = OP_ANSWER;
    it.occupied = occ;
    return it;
  endfunction

  function automatic vrt_out_t mk_out(vrt_kind_t k, logic [23:0] x, logic [7:0] y,
                                      logic [23:0] z);
    vrt_out_t r;
    r.kind   = k;
    r.cell_x = x;
    r.cell_y = y;
    r.cell_z = z;
    return r;
  endfunction

  task automatic add_case(vrt_in_t it, bit typed, vrt_out_t want);
    ray_case_t c;
    c.it    = it;
    c.typed = typed;
    c.want  = want;
    directed_rays.push_back(c);
  endtask

  function automatic logic [STEP_BITS-1:0] pick_step();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return STEP_INF;
    if (sel == 1) return '0;
    if (sel == 2) return STEP_BITS'($urandom);
    return STEP_BITS'($urandom_range(16, 1024));
  endfunction

  // Mostly well-formed traffic: answers while a ray is live, starts otherwise,
  // with a sprinkle of raw noise and restarts in the middle of a walk.
  function automatic vrt_in_t rand_item();
    vrt_in_t      it;
    logic [159:0] raw;
    int           pick;
    for (int i = 0; i < 5; i++) raw[i*32 +: 32] = $urandom;
    it = vrt_in_t'(raw[$bits(vrt_in_t)-1:0]);
    pick = $urandom_range(0, 19);
    if (pick == 0) return it;
    if (walk_on && pick > 1) begin
      it.opcode   = OP_ANSWER;
      it.occupied = ($urandom_range(0, 11) == 0);
      return it;
    end
    it.opcode = OP_START;
    if ($urandom_range(0, 1) == 1) begin
      it.start_x = $urandom_range(0, 8191) - 4096;
      it.start_z = $urandom_range(0, 8191) - 4096;
    end
    it.inv_dir_x = pick_step();
    it.inv_dir_y = pick_step();
    it.inv_dir_z = pick_step();
    // Force equal x and y lengths now and then to exercise the tie exit.
    if ($urandom_range(0, 7) == 0) begin
      it.inv_dir_y          = it.inv_dir_x;
      it.start_y[7:0]       = it.start_x[7:0];
      it.heads_neg_y        = it.heads_neg_x;
    end
    return it;
  endfunction

  // Hold the transaction until accepted, then log what it owes.
  task automatic send_item(vrt_in_t it, bit typed, vrt_out_t want);
    vrt_out_t predicted;
    int       gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = predict_ray(it);
    ray_results_due.push_back(typed ? want : predicted);
    if (predicted.kind != KIND_IDLE) fed_items++;
  endtask

  // Drop valid and let every owed result drain, plus pipeline slack.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (ray_results_due.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reach(logic [REACH_BITS-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(REG_REACH) << REG_LSB;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reach_cfg = v;
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    bad_fields++;
    if (bad_fields <= PRINT_CAP)
      $display("result %0d: %s got %0h want %0h", results_seen, field, got, want);
  endtask

  // Result-side back-pressure in short random bursts.
  always @(posedge clk) begin : result_stalls
    if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      result_ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk) begin : result_check
    vrt_out_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (ray_results_due.size() == 0) begin
        report_mismatch("no result due, kind", 32'(result.kind), '0);
      end else begin
        want = ray_results_due.pop_front();
        if (result.kind !== want.kind)
          report_mismatch("kind", 32'(result.kind), 32'(want.kind));
        if (result.cell_x !== want.cell_x)
          report_mismatch("cell_x", 32'(result.cell_x), 32'(want.cell_x));
        if (result.cell_y !== want.cell_y)
          report_mismatch("cell_y", 32'(result.cell_y), 32'(want.cell_y));
        if (result.cell_z !== want.cell_z)
          report_mismatch("cell_z", 32'(result.cell_z), 32'(want.cell_z));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [REACH_BITS-1:0] reach_plan [5];
    vrt_out_t none;
    none = '0;

    // Answer with no ray live is reported as idle.
    add_case(mk_answer(1'b1), 1'b1, mk_out(KIND_IDLE, '0, '0, '0));
    // Extreme corners: probe the start cell as is.
    add_case(mk_start(1'b0, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000, 3'b000,
                      16'h0100, 16'h0200, 16'h0300),
             1'b1, mk_out(KIND_PROBE, 24'h7FFFFF, 8'hFF, 24'h800000));
    // x wraps around the grid edge.
    add_case(mk_answer(1'b0), 1'b0, none);
    // Height would climb past the top row.
    add_case(mk_answer(1'b0), 1'b1, mk_out(KIND_MISS, '0, '0, '0));
    // Height would drop below the floor on the first place step.
    add_case(mk_start(1'b1, 32'h0, 16'h0000, 32'h0, 3'b010,
                      16'h0100, 16'h0100, 16'h0200),
             1'b1, mk_out(KIND_MISS, '0, '0, '0));
    // Every axis infinite.
    add_case(mk_start(1'b0, 32'h1234_5678, 16'h1234, 32'h8765_4321, 3'b111,
                      16'hFFFF, 16'hFFFF, 16'hFFFF),
             1'b1, mk_out(KIND_MISS, '0, '0, '0));
    // Tie between x and y.
    add_case(mk_start(1'b0, 32'h100, 16'h0100, 32'h100, 3'b000,
                      16'h0100, 16'h0100, 16'hFFFF),
             1'b1, mk_out(KIND_MISS, '0, '0, '0));
    // Place walk with fractional start, ending on the previous cell.
    add_case(mk_start(1'b1, 32'h0000_0080, 16'h4080, 32'hFFFF_FF80, 3'b101,
                      16'h0100, 16'h0180, 16'h0200), 1'b0, none);
    add_case(mk_answer(1'b0), 1'b0, none);
    add_case(mk_answer(1'b0), 1'b0, none);
    add_case(mk_answer(1'b1), 1'b0, none);
    // Zero step size: x keeps length zero, walk continues on demand.
    add_case(mk_start(1'b0, 32'h0000_0300, 16'h1000, 32'h0, 3'b000,
                      16'h0000, 16'hFFFF, 16'hFFFF),
             1'b1, mk_out(KIND_PROBE, 24'd3, 8'd16, 24'd0));
    add_case(mk_answer(1'b0), 1'b0, none);
    add_case(mk_answer(1'b0), 1'b0, none);
    add_case(mk_answer(1'b1), 1'b0, none);
    // Restart while a ray is still live.
    add_case(mk_start(1'b0, 32'hFFFF_FE00, 16'h2000, 32'h0000_0500, 3'b000,
                      16'h0080, 16'h0090, 16'h00A0), 1'b0, none);
    add_case(mk_start(1'b1, 32'h00A0_0040, 16'h8040, 32'h7FFF_FF40, 3'b111,
                      16'h0060, 16'h0070, 16'h0050), 1'b0, none);
    add_case(mk_answer(1'b1), 1'b0, none);
    // Straight x run that runs out of reach on the fifth step.
    add_case(mk_start(1'b0, 32'h0, 16'h0A00, 32'h0, 3'b000,
                      16'h0100, 16'hFFFF, 16'hFFFF),
             1'b1, mk_out(KIND_PROBE, 24'd0, 8'd10, 24'd0));
    repeat (4) add_case(mk_answer(1'b0), 1'b0, none);
    add_case(mk_answer(1'b0), 1'b1, mk_out(KIND_MISS, '0, '0, '0));
    add_case(mk_answer(1'b0), 1'b1, mk_out(KIND_IDLE, '0, '0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rays[i])
      send_item(directed_rays[i].it, directed_rays[i].typed, directed_rays[i].want);

    // Random phases, each at its own reach; the last one runs without idling.
    reach_plan[0] = '0;
    reach_plan[1] = {REACH_BITS{1'b1}};
    reach_plan[2] = 13'd256;
    reach_plan[3] = REACH_BITS'($urandom_range(256, 4096));
    reach_plan[4] = 13'd4096;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      if (p == 4) calm = 1'b1;
      write_reach(reach_plan[p]);
      fed_items = 0;
      while (fed_items < PHASE_ITEMS) send_item(rand_item(), 1'b0, none);
    end

    wait_drained();
    if (bad_fields == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/vrt_pkg.sv
sv/voxel_ray_traversal_unit.sv
tb/sv/voxel_ray_traversal_unit_tb.sv
